>>> rtl/sbwd_pkg.sv
// Package for the separable blur with decay: frame geometry, pixel format,
// configuration register map and shared types. No dependencies.
package sbwd_pkg;

  localparam int WIDTH      = 128;
  localparam int PIXEL_BITS = 16;
  localparam int CNT_W      = $clog2(WIDTH);
  localparam int POS_W      = 7;   // row/column field width on the result stream
  localparam int WEIGHT_W   = 16;
  localparam int DECAY_W    = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  localparam logic [CNT_W-1:0] LAST_POS  = CNT_W'(WIDTH - 1);
  localparam logic [CNT_W-1:0] INNER_LO  = CNT_W'(1);
  localparam logic [CNT_W-1:0] INNER_HI  = CNT_W'(WIDTH - 2);
  localparam logic [CNT_W-1:0] FIRST_INT = CNT_W'(2);

  localparam logic [WEIGHT_W-1:0] SIDE_RST   = WEIGHT_W'(16384);
  localparam logic [WEIGHT_W-1:0] CENTRE_RST = WEIGHT_W'(32768);
  localparam logic [DECAY_W-1:0]  DECAY_RST  = DECAY_W'(65535);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SIDE   = 2'd0,
    CFG_CENTRE = 2'd1,
    CFG_DECAY  = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [WEIGHT_W-1:0] side;
    logic [WEIGHT_W-1:0] centre;
    logic [DECAY_W-1:0]  decay;
  } cfg_t;

  typedef logic [PIXEL_BITS-1:0] pix_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HWAIT,
    ST_VWAIT,
    ST_EMIT
  } state_e;

endpackage

>>> rtl/sbwd_row_mem.sv
// Line buffer for the horizontal pass results of the two previous rows.
// One word per column holds {older, newer}. Depends on sbwd_pkg.
module sbwd_row_mem import sbwd_pkg::*; (
  input  logic                    clk_i,
  input  logic                    we_i,
  input  logic [CNT_W-1:0]        waddr_i,
  input  logic [2*PIXEL_BITS-1:0] wdata_i,
  input  logic                    re_i,
  input  logic [CNT_W-1:0]        raddr_i,
  output logic [2*PIXEL_BITS-1:0] rdata_o
);

  logic [2*PIXEL_BITS-1:0] mem [WIDTH];
  logic [2*PIXEL_BITS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/sbwd_tap.sv
// Four-stage 3-tap filter unit: weighted sum, round, decay multiply, round
// and saturate. Shared by both passes. Depends on sbwd_pkg.
module sbwd_tap import sbwd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic start_i,
  input  pix_t a_i,
  input  pix_t m_i,
  input  pix_t b_i,
  output logic done_o,
  output pix_t value_o
);

  localparam int SUM_W  = PIXEL_BITS + 1;
  localparam int PS_W   = WEIGHT_W + SUM_W;
  localparam int PC_W   = WEIGHT_W + PIXEL_BITS;
  localparam int ACC_W  = PS_W + 2;
  localparam int Q_W    = ACC_W - 16;
  localparam int PR_W   = Q_W + DECAY_W;
  localparam int RND_W  = PR_W + 1;
  localparam int V_W    = RND_W - 16;

  logic [3:0]       vld_q;
  logic [PS_W-1:0]  p_side_q;
  logic [PC_W-1:0]  p_ctr_q;
  logic [Q_W-1:0]   q_q;
  logic [PR_W-1:0]  prod_q;
  pix_t             value_q;

  logic [SUM_W-1:0] sum_ab;
  logic [ACC_W-1:0] acc;
  logic [RND_W-1:0] rnd;
  logic [V_W-1:0]   v;

  assign sum_ab = {1'b0, a_i} + {1'b0, b_i};
  assign acc    = ACC_W'(p_side_q) + ACC_W'(p_ctr_q) + ACC_W'(32768);
  assign rnd    = RND_W'(prod_q) + RND_W'(32768);
  assign v      = rnd[RND_W-1:16];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[2:0], start_i};
    end
  end

  always_ff @(posedge clk_i) begin
    p_side_q <= cfg_i.side * sum_ab;
    p_ctr_q  <= cfg_i.centre * m_i;
    q_q      <= acc[ACC_W-1:16];
    prod_q   <= q_q * cfg_i.decay;
    if (v > V_W'({PIXEL_BITS{1'b1}})) begin
      value_q <= {PIXEL_BITS{1'b1}};
    end else begin
      value_q <= v[PIXEL_BITS-1:0];
    end
  end

  assign done_o  = vld_q[3];
  assign value_o = value_q;

endmodule

>>> rtl/separable_blur_with_decay.sv
// Top level of the separable 3x3 blur with decay: sequencer, pixel history,
// config registers and result register. Uses sbwd_pkg, sbwd_tap, sbwd_row_mem.
//
//  channel   | dir | handshake                    | payload
//  ----------+-----+------------------------------+------------------------------
//  s_axis    | in  | s_axis_tvalid/s_axis_tready  | tdata: pixel_in; tuser: frame_start
//  m_axis    | out | m_axis_tvalid/m_axis_tready  | tdata: row,col,value; tlast: run_end;
//            |     |                              | tuser: frame_end
//  cfg       | in  | cfg_we_i                     | cfg_idx_i, cfg_data_i
//
// Sequence: an item in columns 0 or 1 is only accepted. An item of rows 0 or 1
// is accepted and makes one run of the 4-stage tap unit. An interior item makes
// two runs of the tap unit in series, then emits 1, 2 or 4 results.
// Reset clears counters, pixel history and config; the line buffer is not cleared.
// A stalled last result of an item holds in the output register; the next item is
// accepted meanwhile, and its results wait until the register frees.
module separable_blur_with_decay import sbwd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [15:0]           s_axis_tdata,  // [15:0] pixel_in
  input  logic                  s_axis_tuser,  // [0] frame_start
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [31:0]           m_axis_tdata,  // [6:0] out_row, [13:7] out_col,
                                               // [29:14] out_value, [31:30] zero
  output logic                  m_axis_tlast,  // run_end
  output logic                  m_axis_tuser   // [0] frame_end
);

  state_e state_q, state_d;
  cfg_t   cfg_q;

  logic [CNT_W-1:0] cnt_row_q, cnt_col_q;
  logic [CNT_W-1:0] row_q, col_q;
  pix_t             left_q, far_left_q;
  pix_t             v_q;
  logic [3:0]       mask_q, mask_d;

  logic             m_valid_q, m_valid_d;
  logic [POS_W-1:0] o_row_q, o_col_q;
  pix_t             o_val_q;
  logic             o_last_q, o_fend_q;

  logic             accept;
  logic [CNT_W-1:0] row_cur, col_cur;
  logic             tap_start, tap_done;
  pix_t             tap_a, tap_m, tap_b, tap_val;
  logic             mem_we;
  logic [2*PIXEL_BITS-1:0] mem_rd;
  pix_t             rd_older, rd_newer;

  logic [CNT_W-1:0] c_pos, i_pos, bc_pos, br_pos;
  logic             cb, rb, out_free, load;
  logic [3:0]       pick;
  logic [CNT_W-1:0] e_row, e_col;

  // configuration port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.side   <= SIDE_RST;
      cfg_q.centre <= CENTRE_RST;
      cfg_q.decay  <= DECAY_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SIDE:   cfg_q.side   <= cfg_data_i[WEIGHT_W-1:0];
        CFG_CENTRE: cfg_q.centre <= cfg_data_i[WEIGHT_W-1:0];
        CFG_DECAY:  cfg_q.decay  <= cfg_data_i[DECAY_W-1:0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign row_cur       = s_axis_tuser ? '0 : cnt_row_q;
  assign col_cur       = s_axis_tuser ? '0 : cnt_col_q;

  // position bookkeeping and pixel history
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_row_q  <= '0;
      cnt_col_q  <= '0;
      left_q     <= '0;
      far_left_q <= '0;
      row_q      <= '0;
      col_q      <= '0;
    end else if (accept) begin
      row_q      <= row_cur;
      col_q      <= col_cur;
      left_q     <= s_axis_tdata[PIXEL_BITS-1:0];
      far_left_q <= left_q;
      if (col_cur == LAST_POS) begin
        cnt_col_q <= '0;
        cnt_row_q <= (row_cur == LAST_POS) ? '0 : row_cur + CNT_W'(1);
      end else begin
        cnt_col_q <= col_cur + CNT_W'(1);
        cnt_row_q <= row_cur;
      end
    end
  end

  assign rd_older = mem_rd[2*PIXEL_BITS-1:PIXEL_BITS];
  assign rd_newer = mem_rd[PIXEL_BITS-1:0];

  sbwd_row_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (c_pos),
    .wdata_i ({rd_newer, tap_val}),
    .re_i    (accept),
    .raddr_i (col_cur - CNT_W'(1)),
    .rdata_o (mem_rd)
  );

  sbwd_tap u_tap (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .start_i (tap_start),
    .a_i     (tap_a),
    .m_i     (tap_m),
    .b_i     (tap_b),
    .done_o  (tap_done),
    .value_o (tap_val)
  );

  // output coordinates of the current item
  assign c_pos  = col_q - CNT_W'(1);
  assign i_pos  = row_q - CNT_W'(1);
  assign cb     = (c_pos == INNER_LO) || (c_pos == INNER_HI);
  assign rb     = (i_pos == INNER_LO) || (i_pos == INNER_HI);
  assign bc_pos = (c_pos == INNER_LO) ? '0 : LAST_POS;
  assign br_pos = (i_pos == INNER_LO) ? '0 : LAST_POS;

  assign out_free = !m_valid_q || m_axis_tready;

  always_comb begin
    priority if (mask_q[0]) begin
      pick = 4'b0001; e_row = i_pos;  e_col = c_pos;
    end else if (mask_q[1]) begin
      pick = 4'b0010; e_row = i_pos;  e_col = bc_pos;
    end else if (mask_q[2]) begin
      pick = 4'b0100; e_row = br_pos; e_col = c_pos;
    end else begin
      pick = 4'b1000; e_row = br_pos; e_col = bc_pos;
    end
  end

  // sequencer
  always_comb begin
    state_d   = state_q;
    mask_d    = mask_q;
    tap_start = 1'b0;
    tap_a     = far_left_q;
    tap_m     = left_q;
    tap_b     = s_axis_tdata[PIXEL_BITS-1:0];
    mem_we    = 1'b0;
    load      = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && (col_cur >= FIRST_INT)) begin
          tap_start = 1'b1;
          state_d   = ST_HWAIT;
        end
      end
      ST_HWAIT: begin
        tap_a = rd_older;
        tap_m = rd_newer;
        tap_b = tap_val;
        if (tap_done) begin
          mem_we = 1'b1;
          if (row_q >= FIRST_INT) begin
            tap_start = 1'b1;
            state_d   = ST_VWAIT;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_VWAIT: begin
        if (tap_done) begin
          mask_d  = {cb && rb, rb, cb, 1'b1};
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          load   = 1'b1;
          mask_d = mask_q & ~pick;
          if ((mask_q & ~pick) == 4'b0000) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign m_valid_d = load || (m_valid_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      mask_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      mask_q    <= mask_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_VWAIT && tap_done) begin
      v_q <= tap_val;
    end
    if (load) begin
      o_row_q  <= POS_W'(e_row);
      o_col_q  <= POS_W'(e_col);
      o_val_q  <= v_q;
      o_last_q <= (mask_d == 4'b0000);
      o_fend_q <= (mask_d == 4'b0000) && (row_q == LAST_POS) && (col_q == LAST_POS);
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {2'b00, o_val_q, o_col_q, o_row_q};
  assign m_axis_tlast  = o_last_q;
  assign m_axis_tuser  = o_fend_q;

endmodule
